### hdl/fcs_pkg.sv
`timescale 1ns / 1ps

package fcs_pkg;

   // command item opcodes
   typedef enum logic [2:0] {
      OP_PROGRAM      = 3'd0,
      OP_SECTOR_ERASE = 3'd1,
      OP_CHIP_ERASE   = 3'd2,
      OP_RESET_READ   = 3'd3,
      OP_MANUF_ID     = 3'd4,
      OP_DEVICE_ID    = 3'd5,
      OP_READ_RETURN  = 3'd6
   } op_type;

   // result actions
   typedef enum logic [1:0] {
      ACT_WRITE     = 2'd0,
      ACT_READ      = 2'd1,
      ACT_DONE_OK   = 2'd2,
      ACT_DONE_FAIL = 2'd3
   } action_type;

   // sequencer phase, one-hot
   typedef enum logic [7:0] {
      PH_IDLE   = 8'b0000_0001,
      PH_POLL   = 8'b0000_0010,
      PH_DQ5A   = 8'b0000_0100,
      PH_DQ5B   = 8'b0000_1000,
      PH_FINAL  = 8'b0001_0000,
      PH_SEWAIT = 8'b0010_0000,
      PH_CEWAIT = 8'b0100_0000,
      PH_IDWAIT = 8'b1000_0000
   } phase_type;

   // configuration register indexes
   localparam logic CSR_POLL_LIMIT  = 1'b0;
   localparam logic CSR_RETRY_LIMIT = 1'b1;

   // flash command bytes
   localparam logic [7:0] CMD_UNLOCK1      = 8'hAA;
   localparam logic [7:0] CMD_UNLOCK2      = 8'h55;
   localparam logic [7:0] CMD_PROGRAM      = 8'hA0;
   localparam logic [7:0] CMD_ERASE_SETUP  = 8'h80;
   localparam logic [7:0] CMD_CHIP_ERASE   = 8'h10;
   localparam logic [7:0] CMD_SECTOR_ERASE = 8'h30;
   localparam logic [7:0] CMD_AUTOSELECT   = 8'h90;
   localparam logic [7:0] CMD_READ_RESET   = 8'hF0;

   // addresses at the widest supported bus
   localparam logic [23:0] UNLOCK_A_FULL = 24'h005555;
   localparam logic [23:0] UNLOCK_B_FULL = 24'h002AAA;
   localparam logic [23:0] CHIP_BIT_FULL = 24'h200000;

   // register reset values
   localparam logic [15:0] POLL_LIMIT_RESET  = 16'd10000;
   localparam logic [2:0]  RETRY_LIMIT_RESET = 3'd3;

   // burst buffer depth: longest sequence one item can cause
   localparam int unsigned BURST_DEPTH = 7;

endpackage

### hdl/flash_command_sequencer.sv
`timescale 1ns / 1ps

// A request is taken into the input register and decoded, when the burst buffer is empty or
// its last result is being taken, into a burst of up to seven results; the burst is registered
// in the burst buffer and offered on the port from there. Results leave at one per cycle while
// rsp_ready is high, and the next request is decoded as the last result of the one before leaves.
// Reset (synchronous, active high) empties the input register and burst buffer, idles the
// sequencer and loads poll_limit 10000, retry_limit 3.
module flash_command_sequencer #(
   parameter int ADDR_BITS = 22
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [2:0]                req_op,
   input  logic [ADDR_BITS-1:0]      req_address,
   input  logic [7:0]                req_write_data,
   input  logic [7:0]                req_read_data,
   // result channel
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [1:0]                rsp_action,
   output logic [ADDR_BITS-1:0]      rsp_bus_address,
   output logic [7:0]                rsp_bus_data,
   output logic                      rsp_last,
   // configuration port
   input  logic                      csr_write_enable,
   input  logic                      csr_index,
   input  logic [15:0]               csr_write_data
);

   import fcs_pkg::*;

   localparam int EW = 2 + ADDR_BITS + 8;
   localparam logic [ADDR_BITS-1:0] UNLOCK_A = UNLOCK_A_FULL[ADDR_BITS-1:0];
   localparam logic [ADDR_BITS-1:0] UNLOCK_B = UNLOCK_B_FULL[ADDR_BITS-1:0];
   localparam logic [ADDR_BITS-1:0] CHIP_BIT = CHIP_BIT_FULL[ADDR_BITS-1:0];

   function automatic logic [EW-1:0] mk(action_type act, logic [ADDR_BITS-1:0] a,
                                        logic [7:0] d);
      return {act, a, d};
   endfunction

   // configuration
   logic [15:0] poll_limit_ff;
   logic [2:0]  retry_limit_ff;

   // input register
   logic                 in_valid_ff;
   logic [2:0]           op_ff;
   logic [ADDR_BITS-1:0] addr_ff;
   logic [7:0]           wd_ff;
   logic [7:0]           rd_ff;

   // sequencer state
   phase_type            phase_ff, phase_in;
   logic [ADDR_BITS-1:0] target_address_ff, target_address_in;
   logic [7:0]           target_byte_ff, target_byte_in;
   logic [15:0]          polls_left_ff, polls_left_in;
   logic [2:0]           retries_left_ff, retries_left_in;
   logic                 chip_index_ff, chip_index_in;

   // burst buffer, entry 0 is on the port
   logic [EW-1:0] burst_ff [BURST_DEPTH];
   logic [EW-1:0] ent      [BURST_DEPTH];
   logic [2:0]    cnt_ff;
   logic [2:0]    ent_n;

   logic load;
   logic take;
   logic do_issue;
   logic dq7ok;
   logic [ADDR_BITS-1:0] tchip;
   logic [ADDR_BITS-1:0] ichip;

   assign take      = rsp_valid && rsp_ready;
   assign load      = in_valid_ff && ((cnt_ff == 3'd0) || ((cnt_ff == 3'd1) && rsp_ready));
   assign req_ready = !in_valid_ff || load;

   assign rsp_valid = (cnt_ff != 3'd0);
   assign rsp_last  = (cnt_ff == 3'd1);
   assign rsp_action      = burst_ff[0][EW-1 -: 2];
   assign rsp_bus_address = burst_ff[0][ADDR_BITS+7:8];
   assign rsp_bus_data    = burst_ff[0][7:0];

   assign dq7ok = (rd_ff[7] == target_byte_ff[7]);
   assign tchip = target_address_ff & CHIP_BIT;

   // decode one item into its burst and next state
   always_comb begin
      phase_in          = phase_ff;
      target_address_in = target_address_ff;
      target_byte_in    = target_byte_ff;
      polls_left_in     = polls_left_ff;
      retries_left_in   = retries_left_ff;
      chip_index_in     = chip_index_ff;
      do_issue          = 1'b0;
      ichip             = '0;
      ent_n             = 3'd0;
      for (int i = 0; i < BURST_DEPTH; i++) begin
         ent[i] = '0;
      end

      if (op_ff == OP_READ_RETURN) begin
         unique case (phase_ff)
            PH_POLL: begin
               if (dq7ok) begin
                  phase_in = PH_IDLE;
                  ent[0] = mk(ACT_DONE_OK, target_address_ff, rd_ff);
               end else if (rd_ff[5]) begin
                  phase_in = PH_DQ5A;
                  ent[0] = mk(ACT_READ, target_address_ff, 8'h00);
               end else begin
                  polls_left_in = polls_left_ff - 16'd1;
                  phase_in = (polls_left_in != 16'd0) ? PH_POLL : PH_FINAL;
                  ent[0] = mk(ACT_READ, target_address_ff, 8'h00);
               end
               ent_n = 3'd1;
            end
            PH_DQ5A: begin
               if (dq7ok) begin
                  phase_in = PH_IDLE;
                  ent[0] = mk(ACT_DONE_OK, target_address_ff, rd_ff);
               end else begin
                  phase_in = PH_DQ5B;
                  ent[0] = mk(ACT_READ, target_address_ff, 8'h00);
               end
               ent_n = 3'd1;
            end
            PH_DQ5B: begin
               if (rd_ff == target_byte_ff) begin
                  phase_in = PH_IDLE;
                  ent[0] = mk(ACT_DONE_OK, target_address_ff, rd_ff);
               end else begin
                  polls_left_in = polls_left_ff - 16'd1;
                  phase_in = (polls_left_in != 16'd0) ? PH_POLL : PH_FINAL;
                  ent[0] = mk(ACT_READ, target_address_ff, 8'h00);
               end
               ent_n = 3'd1;
            end
            PH_FINAL: begin
               if (rd_ff == target_byte_ff) begin
                  phase_in = PH_IDLE;
                  ent[0] = mk(ACT_DONE_OK, target_address_ff, rd_ff);
                  ent_n = 3'd1;
               end else if (retries_left_ff == 3'd0) begin
                  phase_in = PH_IDLE;
                  ent[0] = mk(ACT_DONE_FAIL, target_address_ff, rd_ff);
                  ent_n = 3'd1;
               end else begin
                  retries_left_in = retries_left_ff - 3'd1;
                  do_issue = 1'b1;
               end
            end
            PH_SEWAIT: begin
               if (rd_ff[3]) begin
                  ent[0] = mk(ACT_READ, target_address_ff, 8'h00);
                  ent_n = 3'd1;
               end else begin
                  ent[0] = mk(ACT_WRITE, tchip | UNLOCK_A, CMD_UNLOCK1);
                  ent[1] = mk(ACT_WRITE, tchip | UNLOCK_B, CMD_UNLOCK2);
                  ent[2] = mk(ACT_WRITE, tchip | UNLOCK_A, CMD_ERASE_SETUP);
                  ent[3] = mk(ACT_WRITE, tchip | UNLOCK_A, CMD_UNLOCK1);
                  ent[4] = mk(ACT_WRITE, tchip | UNLOCK_B, CMD_UNLOCK2);
                  ent[5] = mk(ACT_WRITE, target_address_ff, CMD_SECTOR_ERASE);
                  ent[6] = mk(ACT_DONE_OK, target_address_ff, 8'h00);
                  ent_n = 3'd7;
                  phase_in = PH_IDLE;
               end
            end
            PH_CEWAIT: begin
               if (!rd_ff[7]) begin
                  ent[0] = mk(ACT_READ, (chip_index_ff ? CHIP_BIT : '0) | UNLOCK_A, 8'h00);
                  ent_n = 3'd1;
               end else if (!chip_index_ff) begin
                  // first chip done, start on the second
                  chip_index_in = 1'b1;
                  ent[0] = mk(ACT_WRITE, CHIP_BIT | UNLOCK_A, CMD_UNLOCK1);
                  ent[1] = mk(ACT_WRITE, CHIP_BIT | UNLOCK_B, CMD_UNLOCK2);
                  ent[2] = mk(ACT_WRITE, CHIP_BIT | UNLOCK_A, CMD_ERASE_SETUP);
                  ent[3] = mk(ACT_WRITE, CHIP_BIT | UNLOCK_A, CMD_UNLOCK1);
                  ent[4] = mk(ACT_WRITE, CHIP_BIT | UNLOCK_B, CMD_UNLOCK2);
                  ent[5] = mk(ACT_WRITE, CHIP_BIT | UNLOCK_A, CMD_CHIP_ERASE);
                  ent[6] = mk(ACT_READ, CHIP_BIT | UNLOCK_A, 8'h00);
                  ent_n = 3'd7;
               end else begin
                  phase_in = PH_IDLE;
                  ent[0] = mk(ACT_DONE_OK, '0, 8'h00);
                  ent_n = 3'd1;
               end
            end
            PH_IDWAIT: begin
               phase_in = PH_IDLE;
               ent[0] = mk(ACT_DONE_OK, target_address_ff, rd_ff);
               ent_n = 3'd1;
            end
            default: begin
               // idle: stray read return, nothing to do
            end
         endcase
      end else if (phase_ff == PH_IDLE) begin
         case (op_ff)
            OP_PROGRAM: begin
               target_address_in = addr_ff;
               target_byte_in    = wd_ff;
               retries_left_in   = retry_limit_ff;
               do_issue          = 1'b1;
            end
            OP_SECTOR_ERASE: begin
               target_address_in = addr_ff;
               phase_in = PH_SEWAIT;
               ent[0] = mk(ACT_READ, addr_ff, 8'h00);
               ent_n = 3'd1;
            end
            OP_CHIP_ERASE: begin
               chip_index_in = 1'b0;
               ent[0] = mk(ACT_WRITE, UNLOCK_A, CMD_UNLOCK1);
               ent[1] = mk(ACT_WRITE, UNLOCK_B, CMD_UNLOCK2);
               ent[2] = mk(ACT_WRITE, UNLOCK_A, CMD_ERASE_SETUP);
               ent[3] = mk(ACT_WRITE, UNLOCK_A, CMD_UNLOCK1);
               ent[4] = mk(ACT_WRITE, UNLOCK_B, CMD_UNLOCK2);
               ent[5] = mk(ACT_WRITE, UNLOCK_A, CMD_CHIP_ERASE);
               ent[6] = mk(ACT_READ, UNLOCK_A, 8'h00);
               ent_n = 3'd7;
               phase_in = PH_CEWAIT;
            end
            OP_RESET_READ: begin
               ent[0] = mk(ACT_WRITE, UNLOCK_A, CMD_UNLOCK1);
               ent[1] = mk(ACT_WRITE, UNLOCK_B, CMD_UNLOCK2);
               ent[2] = mk(ACT_WRITE, UNLOCK_A, CMD_READ_RESET);
               ent[3] = mk(ACT_WRITE, CHIP_BIT | UNLOCK_A, CMD_UNLOCK1);
               ent[4] = mk(ACT_WRITE, CHIP_BIT | UNLOCK_B, CMD_UNLOCK2);
               ent[5] = mk(ACT_WRITE, CHIP_BIT | UNLOCK_A, CMD_READ_RESET);
               ent[6] = mk(ACT_DONE_OK, '0, 8'h00);
               ent_n = 3'd7;
            end
            OP_MANUF_ID, OP_DEVICE_ID: begin
               target_address_in = (op_ff == OP_MANUF_ID) ? '0 : ADDR_BITS'(1);
               ent[0] = mk(ACT_WRITE, UNLOCK_A, CMD_UNLOCK1);
               ent[1] = mk(ACT_WRITE, UNLOCK_B, CMD_UNLOCK2);
               ent[2] = mk(ACT_WRITE, UNLOCK_A, CMD_AUTOSELECT);
               ent[3] = mk(ACT_READ, target_address_in, 8'h00);
               ent_n = 3'd4;
               phase_in = PH_IDWAIT;
            end
            default: begin
               // unused opcode, ignored
            end
         endcase
      end

      // program sequence: unlock, program command, data, first status read
      if (do_issue) begin
         ichip  = target_address_in & CHIP_BIT;
         ent[0] = mk(ACT_WRITE, ichip | UNLOCK_A, CMD_UNLOCK1);
         ent[1] = mk(ACT_WRITE, ichip | UNLOCK_B, CMD_UNLOCK2);
         ent[2] = mk(ACT_WRITE, ichip | UNLOCK_A, CMD_PROGRAM);
         ent[3] = mk(ACT_WRITE, target_address_in, target_byte_in);
         ent[4] = mk(ACT_READ, target_address_in, 8'h00);
         ent_n = 3'd5;
         polls_left_in = poll_limit_ff;
         phase_in = (poll_limit_ff != 16'd0) ? PH_POLL : PH_FINAL;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         poll_limit_ff     <= POLL_LIMIT_RESET;
         retry_limit_ff    <= RETRY_LIMIT_RESET;
         in_valid_ff       <= 1'b0;
         cnt_ff            <= 3'd0;
         phase_ff          <= PH_IDLE;
         target_address_ff <= '0;
         target_byte_ff    <= '0;
         polls_left_ff     <= '0;
         retries_left_ff   <= '0;
         chip_index_ff     <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_POLL_LIMIT) begin
               poll_limit_ff <= csr_write_data;
            end else if (csr_index == CSR_RETRY_LIMIT) begin
               retry_limit_ff <= csr_write_data[2:0];
            end
         end
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
         end else if (load) begin
            in_valid_ff <= 1'b0;
         end
         if (load) begin
            cnt_ff            <= ent_n;
            phase_ff          <= phase_in;
            target_address_ff <= target_address_in;
            target_byte_ff    <= target_byte_in;
            polls_left_ff     <= polls_left_in;
            retries_left_ff   <= retries_left_in;
            chip_index_ff     <= chip_index_in;
         end else if (take) begin
            cnt_ff <= cnt_ff - 3'd1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         op_ff   <= req_op;
         addr_ff <= req_address;
         wd_ff   <= req_write_data;
         rd_ff   <= req_read_data;
      end
      if (load) begin
         burst_ff <= ent;
      end else if (take) begin
         for (int i = 0; i < BURST_DEPTH - 1; i++) begin
            burst_ff[i] <= burst_ff[i+1];
         end
      end
   end

   // a decoded burst with results is offered in the next cycle
   a_burst_offered: assert property (@(posedge clock) disable iff (reset)
      (load && (ent_n != 3'd0)) |=> rsp_valid)
      else $error("decoded burst not offered");

   // polling never runs with the budget used up
   a_poll_budget: assert property (@(posedge clock) disable iff (reset)
      !((phase_ff == PH_POLL) && (polls_left_ff == 16'd0)))
      else $error("polling with zero budget");

   // a held request stays in the input register until decoded
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !load) |=> (in_valid_ff && $stable(op_ff) && $stable(rd_ff)))
      else $error("pending request lost");

endmodule

### verif/tb_flash_command_sequencer.sv
`timescale 1ns / 1ps

module tb_flash_command_sequencer;
   import fcs_pkg::*;

   localparam int ADDR_BITS        = 22;
   localparam int WATCHDOG_LIMIT   = 3000;
   localparam int SETTLE_CYCLES    = 24;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int LONG_HOLD_AFTER  = 150;
   localparam int PRINT_LIMIT      = 200;

   localparam logic [2:0] OP_UNUSED = 3'd7;

   localparam logic [ADDR_BITS-1:0] UNLOCK_A = UNLOCK_A_FULL[ADDR_BITS-1:0];
   localparam logic [ADDR_BITS-1:0] UNLOCK_B = UNLOCK_B_FULL[ADDR_BITS-1:0];
   localparam logic [ADDR_BITS-1:0] CHIP_BIT = CHIP_BIT_FULL[ADDR_BITS-1:0];

   typedef struct packed {
      logic [2:0]           op;
      logic [ADDR_BITS-1:0] address;
      logic [7:0]           write_data;
      logic [7:0]           read_data;
   } flash_request_type;

   typedef struct packed {
      action_type           action;
      logic [ADDR_BITS-1:0] bus_address;
      logic [7:0]           bus_data;
      logic                 last;
   } bus_cycle_type;

   typedef struct packed {
      phase_type            phase;
      logic [ADDR_BITS-1:0] target_address;
      logic [7:0]           target_byte;
      logic [15:0]          polls_left;
      logic [2:0]           retries_left;
      logic                 chip_index;
   } sequencer_state_type;

   typedef struct packed {
      logic [15:0] poll_limit;
      logic [2:0]  retry_limit;
   } limits_type;

   // DUT connections
   logic                 clock;
   logic                 reset            = 1'b1;
   logic                 req_valid        = 1'b0;
   logic                 req_ready;
   logic [2:0]           req_op           = '0;
   logic [ADDR_BITS-1:0] req_address      = '0;
   logic [7:0]           req_write_data   = '0;
   logic [7:0]           req_read_data    = '0;
   logic                 rsp_valid;
   logic                 rsp_ready        = 1'b0;
   logic [1:0]           rsp_action;
   logic [ADDR_BITS-1:0] rsp_bus_address;
   logic [7:0]           rsp_bus_data;
   logic                 rsp_last;
   logic                 csr_write_enable = 1'b0;
   logic                 csr_index        = 1'b0;
   logic [15:0]          csr_write_data   = '0;

   flash_command_sequencer #(.ADDR_BITS(ADDR_BITS)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_address     (req_address),
      .req_write_data  (req_write_data),
      .req_read_data   (req_read_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_action      (rsp_action),
      .rsp_bus_address (rsp_bus_address),
      .rsp_bus_data    (rsp_bus_data),
      .rsp_last        (rsp_last),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // testbench bookkeeping
   flash_request_type   pending_requests[$];
   bus_cycle_type       expected_bus_cycles[$];
   bus_cycle_type       step_cycles[$];
   limits_type          limits = '{poll_limit: POLL_LIMIT_RESET,
                                   retry_limit: RETRY_LIMIT_RESET};
   sequencer_state_type tracked_state;
   sequencer_state_type planned_state;

   int   mismatch_count = 0;
   int   planned_items  = 0;
   int   idle_cycles    = 0;
   bit   request_on_bus = 1'b0;
   int   burst_left     = 0;
   int   gap_left       = 0;
   bit   drain_hold     = 1'b0;
   int   delivered      = 0;
   int   hold_left      = 0;
   bit   long_hold_done = 1'b0;
   int   stall_tick     = 0;
   int   stall_mode     = 0;

   // ---------------------------------------------------------------
   // Sequencer prediction
   // ---------------------------------------------------------------
   function automatic sequencer_state_type idle_state();
      sequencer_state_type s;
      s                = '0;
      s.phase          = PH_IDLE;
      return s;
   endfunction

   function automatic void emit(action_type act, logic [ADDR_BITS-1:0] addr, logic [7:0] data);
      bus_cycle_type c;
      c.action      = act;
      c.bus_address = addr;
      c.bus_data    = data;
      c.last        = 1'b0;
      step_cycles.push_back(c);
   endfunction

   // AA/55 unlock followed by a command byte
   function automatic void emit_unlock(logic [ADDR_BITS-1:0] chip, logic [7:0] cmd);
      emit(ACT_WRITE, chip | UNLOCK_A, CMD_UNLOCK1);
      emit(ACT_WRITE, chip | UNLOCK_B, CMD_UNLOCK2);
      emit(ACT_WRITE, chip | UNLOCK_A, cmd);
   endfunction

   function automatic void emit_erase_setup(logic [ADDR_BITS-1:0] chip);
      emit_unlock(chip, CMD_ERASE_SETUP);
      emit(ACT_WRITE, chip | UNLOCK_A, CMD_UNLOCK1);
      emit(ACT_WRITE, chip | UNLOCK_B, CMD_UNLOCK2);
   endfunction

   // one full program attempt, then the first status read
   function automatic void program_attempt(inout sequencer_state_type s);
      emit_unlock(s.target_address & CHIP_BIT, CMD_PROGRAM);
      emit(ACT_WRITE, s.target_address, s.target_byte);
      s.polls_left = limits.poll_limit;
      if (s.polls_left != 0) begin
         s.phase = PH_POLL;
      end else begin
         s.phase = PH_FINAL;
      end
      emit(ACT_READ, s.target_address, 8'h00);
   endfunction

   function automatic void spend_poll(inout sequencer_state_type s);
      s.polls_left = s.polls_left - 16'd1;
      if (s.polls_left != 0) begin
         s.phase = PH_POLL;
      end else begin
         s.phase = PH_FINAL;
      end
      emit(ACT_READ, s.target_address, 8'h00);
   endfunction

   function automatic void close_out(inout sequencer_state_type s, input action_type act,
                                     input logic [ADDR_BITS-1:0] addr, input logic [7:0] data);
      s.phase = PH_IDLE;
      emit(act, addr, data);
   endfunction

   // advance the sequencer by one request; bus cycles land in step_cycles
   function automatic int sequencer_step(inout sequencer_state_type s,
                                         input flash_request_type r);
      logic                 dq7_match;
      logic [ADDR_BITS-1:0] chip;
      bus_cycle_type        tail;
      step_cycles.delete();
      dq7_match = (r.read_data[7] == s.target_byte[7]);
      if (r.op == OP_READ_RETURN) begin
         case (s.phase)
            PH_POLL: begin
               if (dq7_match) begin
                  close_out(s, ACT_DONE_OK, s.target_address, r.read_data);
               end else if (r.read_data[5]) begin
                  s.phase = PH_DQ5A;
                  emit(ACT_READ, s.target_address, 8'h00);
               end else begin
                  spend_poll(s);
               end
            end
            PH_DQ5A: begin
               if (dq7_match) begin
                  close_out(s, ACT_DONE_OK, s.target_address, r.read_data);
               end else begin
                  s.phase = PH_DQ5B;
                  emit(ACT_READ, s.target_address, 8'h00);
               end
            end
            PH_DQ5B: begin
               if (r.read_data == s.target_byte) begin
                  close_out(s, ACT_DONE_OK, s.target_address, r.read_data);
               end else begin
                  spend_poll(s);
               end
            end
            PH_FINAL: begin
               if (r.read_data == s.target_byte) begin
                  close_out(s, ACT_DONE_OK, s.target_address, r.read_data);
               end else if (s.retries_left == 0) begin
                  close_out(s, ACT_DONE_FAIL, s.target_address, r.read_data);
               end else begin
                  s.retries_left = s.retries_left - 3'd1;
                  program_attempt(s);
               end
            end
            PH_SEWAIT: begin
               // erase timer still running: poll again
               if (r.read_data[3]) begin
                  emit(ACT_READ, s.target_address, 8'h00);
               end else begin
                  emit_erase_setup(s.target_address & CHIP_BIT);
                  emit(ACT_WRITE, s.target_address, CMD_SECTOR_ERASE);
                  close_out(s, ACT_DONE_OK, s.target_address, 8'h00);
               end
            end
            PH_CEWAIT: begin
               chip = s.chip_index ? CHIP_BIT : '0;
               if (!r.read_data[7]) begin
                  emit(ACT_READ, chip | UNLOCK_A, 8'h00);
               end else if (!s.chip_index) begin
                  s.chip_index = 1'b1;
                  emit_erase_setup(CHIP_BIT);
                  emit(ACT_WRITE, CHIP_BIT | UNLOCK_A, CMD_CHIP_ERASE);
                  emit(ACT_READ, CHIP_BIT | UNLOCK_A, 8'h00);
               end else begin
                  close_out(s, ACT_DONE_OK, '0, 8'h00);
               end
            end
            PH_IDWAIT: begin
               close_out(s, ACT_DONE_OK, s.target_address, r.read_data);
            end
            default: begin
               // stray read return while idle
            end
         endcase
      end else if (r.op <= OP_DEVICE_ID && s.phase == PH_IDLE) begin
         case (r.op)
            OP_PROGRAM: begin
               s.target_address = r.address;
               s.target_byte    = r.write_data;
               s.retries_left   = limits.retry_limit;
               program_attempt(s);
            end
            OP_SECTOR_ERASE: begin
               s.target_address = r.address;
               s.phase          = PH_SEWAIT;
               emit(ACT_READ, s.target_address, 8'h00);
            end
            OP_CHIP_ERASE: begin
               s.chip_index = 1'b0;
               emit_erase_setup('0);
               emit(ACT_WRITE, UNLOCK_A, CMD_CHIP_ERASE);
               emit(ACT_READ, UNLOCK_A, 8'h00);
               s.phase = PH_CEWAIT;
            end
            OP_RESET_READ: begin
               emit_unlock('0, CMD_READ_RESET);
               emit_unlock(CHIP_BIT, CMD_READ_RESET);
               emit(ACT_DONE_OK, '0, 8'h00);
            end
            default: begin
               s.target_address = (r.op == OP_MANUF_ID) ? '0 : ADDR_BITS'(1);
               emit_unlock('0, CMD_AUTOSELECT);
               emit(ACT_READ, s.target_address, 8'h00);
               s.phase = PH_IDWAIT;
            end
         endcase
      end
      if (step_cycles.size() > 0) begin
         tail      = step_cycles.pop_back();
         tail.last = 1'b1;
         step_cycles.push_back(tail);
      end
      return step_cycles.size();
   endfunction

   // ---------------------------------------------------------------
   // Request planning: a second copy of the sequencer state tells the
   // planner which read is pending, so sequences stay well formed
   // ---------------------------------------------------------------
   task automatic queue_request(input logic [2:0] op, input logic [ADDR_BITS-1:0] addr,
                                input logic [7:0] wdata, input logic [7:0] rdata);
      flash_request_type r;
      r.op         = op;
      r.address    = addr;
      r.write_data = wdata;
      r.read_data  = rdata;
      if (sequencer_step(planned_state, r) > 0) begin
         planned_items++;
      end
      pending_requests.push_back(r);
   endtask

   // status byte steered towards every branch of the pending read
   function automatic logic [7:0] steered_status(input sequencer_state_type s);
      logic [7:0] d;
      d = 8'($urandom);
      case (s.phase)
         PH_POLL: begin
            case ($urandom_range(0, 3))
               0: d[7] = s.target_byte[7];
               1: begin
                  d[7] = ~s.target_byte[7];
                  d[5] = 1'b1;
               end
               default: begin
                  d[7] = ~s.target_byte[7];
                  d[5] = 1'b0;
               end
            endcase
         end
         PH_DQ5A: d[7] = ($urandom_range(0, 1) == 0) ? s.target_byte[7] : ~s.target_byte[7];
         PH_DQ5B, PH_FINAL: begin
            if ($urandom_range(0, 4) < 2) begin
               d = s.target_byte;
            end else begin
               d = s.target_byte ^ 8'($urandom_range(1, 255));
            end
         end
         default: begin
         end
      endcase
      return d;
   endfunction

   function automatic logic [2:0] random_command();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 8) return OP_PROGRAM;
      if (pick < 11) return OP_SECTOR_ERASE;
      if (pick < 13) return OP_CHIP_ERASE;
      if (pick < 15) return OP_RESET_READ;
      if (pick < 17) return OP_MANUF_ID;
      return OP_DEVICE_ID;
   endfunction

   task automatic plan_random(input int count);
      int         start;
      logic [2:0] op;
      start = planned_items;
      while (planned_items - start < count || planned_state.phase != PH_IDLE) begin
         if ($urandom_range(0, 9) == 0) begin
            // noise: stray return when idle, command while a read is pending, unused op
            if (planned_state.phase == PH_IDLE) begin
               op = ($urandom_range(0, 1) == 0) ? OP_READ_RETURN : OP_UNUSED;
            end else begin
               op = ($urandom_range(0, 1) == 0) ? 3'($urandom_range(0, 5)) : OP_UNUSED;
            end
            queue_request(op, ADDR_BITS'($urandom), 8'($urandom), 8'($urandom));
         end else if (planned_state.phase == PH_IDLE) begin
            queue_request(random_command(), ADDR_BITS'($urandom), 8'($urandom), 8'($urandom));
         end else begin
            queue_request(OP_READ_RETURN, ADDR_BITS'($urandom), 8'($urandom),
                          steered_status(planned_state));
         end
      end
   endtask

   // ---------------------------------------------------------------
   // Phase control
   // ---------------------------------------------------------------
   task automatic wait_for_drain();
      while (pending_requests.size() != 0 || request_on_bus || expected_bus_cycles.size() != 0)
         @(posedge clock);
      // an ignored request may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_limits(input logic [15:0] poll, input logic [2:0] retry);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_POLL_LIMIT;
      csr_write_data   <= poll;
      @(posedge clock);
      csr_index        <= CSR_RETRY_LIMIT;
      csr_write_data   <= {13'd0, retry};
      @(posedge clock);
      csr_write_enable <= 1'b0;
      limits.poll_limit  = poll;
      limits.retry_limit = retry;
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("%0t ns: %s got 0x%0h expected 0x%0h", $time, what, got, want);
   endtask

   initial begin
      tracked_state = idle_state();
      planned_state = idle_state();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed requests at reset limits
      queue_request(OP_RESET_READ, '1, 8'hFF, 8'hFF);
      queue_request(OP_MANUF_ID, '0, 8'h00, 8'h00);
      queue_request(OP_READ_RETURN, '1, 8'h00, 8'hFF);
      queue_request(OP_DEVICE_ID, '1, 8'hFF, 8'hFF);
      queue_request(OP_READ_RETURN, '0, 8'hFF, 8'h00);
      queue_request(OP_READ_RETURN, '0, 8'h00, 8'hA5);   // stray return while idle
      queue_request(OP_UNUSED, '1, 8'hFF, 8'hFF);
      // program, ignored command while busy, data polling passes at once
      queue_request(OP_PROGRAM, '1, 8'hFF, 8'h00);
      queue_request(OP_CHIP_ERASE, '0, 8'h00, 8'h00);
      queue_request(OP_READ_RETURN, '0, 8'h00, 8'h80);
      // timeout bit set, first re-read fails polarity, second re-read matches the cell
      queue_request(OP_PROGRAM, '0, 8'h00, 8'h00);
      queue_request(OP_READ_RETURN, '0, 8'h00, 8'hA0);
      queue_request(OP_READ_RETURN, '0, 8'h00, 8'h80);
      queue_request(OP_READ_RETURN, '0, 8'h00, 8'h00);
      // second chip: timeout bit set, then polarity matches
      queue_request(OP_PROGRAM, ADDR_BITS'(22'h200001), 8'h5A, 8'h00);
      queue_request(OP_READ_RETURN, '0, 8'h00, 8'hA0);
      queue_request(OP_READ_RETURN, '0, 8'h00, 8'h5A);
      // sector erase: timer bit set once, then clear
      queue_request(OP_SECTOR_ERASE, ADDR_BITS'(22'h2ABCDE), 8'h00, 8'h00);
      queue_request(OP_READ_RETURN, '0, 8'h00, 8'h08);
      queue_request(OP_READ_RETURN, '0, 8'h00, 8'hF7);
      // chip erase: chip 0 busy once, then both done
      queue_request(OP_CHIP_ERASE, '0, 8'h00, 8'h00);
      queue_request(OP_READ_RETURN, '0, 8'h00, 8'h7F);
      queue_request(OP_READ_RETURN, '0, 8'h00, 8'h80);
      queue_request(OP_READ_RETURN, '0, 8'h00, 8'hFF);
      wait_for_drain();

      apply_limits(16'd1, 3'd0);
      plan_random(20);
      wait_for_drain();

      // zero poll budget goes straight to the final compare
      apply_limits(16'd0, 3'd2);
      plan_random(18);
      wait_for_drain();

      apply_limits(16'd3, 3'd7);
      plan_random(30);
      wait_for_drain();

      apply_limits(16'hFFFF, 3'd7);
      plan_random(14);
      wait_for_drain();

      apply_limits(16'd2, 3'd1);
      plan_random(32);
      wait_for_drain();

      if (mismatch_count == 0) begin
         $display("flash_command_sequencer: match");
      end else begin
         $display("flash_command_sequencer: mismatch");
      end
      $finish;
   end

   // ---------------------------------------------------------------
   // Request driver: bursts with random gaps, occasionally waiting for
   // all outstanding results before offering more
   // ---------------------------------------------------------------
   task automatic present_next();
      flash_request_type r;
      r = pending_requests.pop_front();
      req_op         <= r.op;
      req_address    <= r.address;
      req_write_data <= r.write_data;
      req_read_data  <= r.read_data;
      request_on_bus  = 1'b1;
   endtask

   always @(posedge clock) begin
      flash_request_type r;
      int                gap_kind;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && req_ready) begin
         // accepted request: predict its bus cycles
         r.op         = req_op;
         r.address    = req_address;
         r.write_data = req_write_data;
         r.read_data  = req_read_data;
         void'(sequencer_step(tracked_state, r));
         foreach (step_cycles[i]) expected_bus_cycles.push_back(step_cycles[i]);
         request_on_bus = 1'b0;
         burst_left--;
         if (burst_left > 0 && pending_requests.size() > 0) begin
            present_next();
         end else begin
            req_valid <= 1'b0;
            gap_kind = $urandom_range(0, 15);
            if (gap_kind == 0) begin
               drain_hold = 1'b1;
               gap_left   = 0;
            end else if (gap_kind < 6) begin
               gap_left = 0;
            end else begin
               gap_left = $urandom_range(1, 10);
            end
         end
      end else if (!req_valid && pending_requests.size() > 0) begin
         if (gap_left > 0) begin
            gap_left--;
         end else if (!(drain_hold && expected_bus_cycles.size() > 0)) begin
            drain_hold = 1'b0;
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(1, 8);
            present_next();
            req_valid <= 1'b1;
         end
      end
   end

   // result acceptance: own stall pattern plus one long hold-off
   always @(posedge clock) begin
      logic next_ready;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) delivered++;
         stall_tick++;
         if (!long_hold_done && delivered >= LONG_HOLD_AFTER) begin
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            next_ready = 1'b0;
         end else begin
            if (stall_tick % 64 == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
               0:       next_ready = 1'b1;
               1:       next_ready = ($urandom_range(0, 1) == 0);
               2:       next_ready = ($urandom_range(0, 3) == 0);
               default: next_ready = (stall_tick % 5) < 3;
            endcase
         end
         rsp_ready <= next_ready;
      end
   end

   // result checker
   always @(posedge clock) begin
      bus_cycle_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bus_cycles.size() == 0) begin
            report_mismatch("unexpected result, action", 32'(rsp_action), 32'(0));
         end else begin
            want = expected_bus_cycles.pop_front();
            if (rsp_action !== want.action)
               report_mismatch("action", 32'(rsp_action), 32'(want.action));
            if (rsp_bus_address !== want.bus_address)
               report_mismatch("bus_address", 32'(rsp_bus_address), 32'(want.bus_address));
            if (rsp_bus_data !== want.bus_data)
               report_mismatch("bus_data", 32'(rsp_bus_data), 32'(want.bus_data));
            if (rsp_last !== want.last)
               report_mismatch("last", 32'(rsp_last), 32'(want.last));
         end
      end
   end

   // no progress on either channel for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t ns: watchdog expired, %0d results outstanding", $time,
                  expected_bus_cycles.size());
         $display("flash_command_sequencer: mismatch");
         $finish;
      end
   end

endmodule

### flash_command_sequencer.f
hdl/fcs_pkg.sv
hdl/flash_command_sequencer.sv
verif/tb_flash_command_sequencer.sv
